// ----- rtl/mrpt_pkg.sv -----
// Package for the 64-bit Miller-Rabin primality unit.
// Holds widths, the small-prime and witness tables. No dependencies.
package mrpt_pkg;
  localparam int unsigned DataWidth = 64;
  localparam int unsigned SmallCount = 25;
  localparam int unsigned WitCount = 7;
  localparam logic [DataWidth-1:0] SmallLimitSq = 64'd10201;

  function automatic logic [6:0] small_prime(input logic [4:0] idx);
    logic [6:0] p;
    case (idx)
      5'd0: p = 7'd2;   5'd1: p = 7'd3;   5'd2: p = 7'd5;   5'd3: p = 7'd7;
      5'd4: p = 7'd11;  5'd5: p = 7'd13;  5'd6: p = 7'd17;  5'd7: p = 7'd19;
      5'd8: p = 7'd23;  5'd9: p = 7'd29;  5'd10: p = 7'd31; 5'd11: p = 7'd37;
      5'd12: p = 7'd41; 5'd13: p = 7'd43; 5'd14: p = 7'd47; 5'd15: p = 7'd53;
      5'd16: p = 7'd59; 5'd17: p = 7'd61; 5'd18: p = 7'd67; 5'd19: p = 7'd71;
      5'd20: p = 7'd73; 5'd21: p = 7'd79; 5'd22: p = 7'd83; 5'd23: p = 7'd89;
      5'd24: p = 7'd97;
      default: p = 7'd2;
    endcase
    return p;
  endfunction

  function automatic logic [30:0] witness(input logic [2:0] idx);
    logic [30:0] w;
    case (idx)
      3'd0: w = 31'd2;
      3'd1: w = 31'd325;
      3'd2: w = 31'd9375;
      3'd3: w = 31'd28178;
      3'd4: w = 31'd450775;
      3'd5: w = 31'd9780504;
      3'd6: w = 31'd1795265022;
      default: w = 31'd2;
    endcase
    return w;
  endfunction
endpackage

// ----- rtl/mrpt_mulmod.sv -----
// Bit-serial modular multiplier: acc = x * y mod m, one multiplier bit per cycle.
// Depends on mrpt_pkg. User keeps x < m (not enforced); acc stays < m.
module mrpt_mulmod import mrpt_pkg::*; #(
  parameter int unsigned Width = DataWidth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [Width-1:0] x_i,
  input  logic [Width-1:0] y_i,
  input  logic [Width-1:0] m_i,
  output logic             done_o,
  output logic [Width-1:0] p_o
);
  localparam int unsigned CntW = $clog2(Width + 1);
  logic [Width-1:0] acc_q, acc_d, y_q, y_d, x_q, m_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d, done_q, done_d;
  logic [Width:0] dbl, sum;
  logic [Width-1:0] a1;

  always_comb begin
    dbl = {acc_q, 1'b0};
    a1 = (dbl >= {1'b0, m_q}) ? Width'(dbl - {1'b0, m_q}) : dbl[Width-1:0];
    sum = {1'b0, a1} + {1'b0, x_q};
    acc_d = acc_q; y_d = y_q; cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      acc_d = '0; y_d = y_i; cnt_d = CntW'(Width); busy_d = 1'b1;
    end else if (busy_q) begin
      if (y_q[Width-1])
        acc_d = (sum >= {1'b0, m_q}) ? Width'(sum - {1'b0, m_q}) : sum[Width-1:0];
      else
        acc_d = a1;
      y_d = {y_q[Width-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d; y_q <= y_d;
    if (start_i) begin
      x_q <= x_i; m_q <= m_i;
    end
  end

  assign done_o = done_q;
  assign p_o = acc_q;
endmodule

// ----- rtl/mrpt_remainder.sv -----
// Bit-serial remainder unit: r = a mod b by restoring division, one bit per cycle.
// Depends on mrpt_pkg. Used for trial division and for reducing witnesses.
module mrpt_remainder import mrpt_pkg::*; #(
  parameter int unsigned Width = DataWidth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [Width-1:0] a_i,
  input  logic [Width-1:0] b_i,
  output logic             done_o,
  output logic [Width-1:0] r_o
);
  localparam int unsigned CntW = $clog2(Width + 1);
  logic [Width-1:0] r_q, r_d, a_q, a_d, b_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d, done_q, done_d;
  logic [Width:0] sh;

  always_comb begin
    sh = {r_q, a_q[Width-1]};
    r_d = r_q; a_d = a_q; cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      r_d = '0; a_d = a_i; cnt_d = CntW'(Width); busy_d = 1'b1;
    end else if (busy_q) begin
      r_d = (sh >= {1'b0, b_q}) ? Width'(sh - {1'b0, b_q}) : sh[Width-1:0];
      a_d = {a_q[Width-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d; a_q <= a_d;
    if (start_i) b_q <= b_i;
  end

  assign done_o = done_q;
  assign r_o = r_q;
endmodule

// ----- rtl/miller_rabin_prime_test_64_unit.sv -----
// Deterministic 64-bit primality unit: trial division by primes below 100, then
// Miller-Rabin with seven fixed witnesses on one shared bit-serial multiplier.
// Trial division by each small prime comes first; then each witness takes one
// reduction of the witness mod n and up to 126 modular products.
// One item at a time; the next is accepted once the result register is free.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle with no result.
module miller_rabin_prime_test_64_unit import mrpt_pkg::*; #(
  parameter int unsigned Width = DataWidth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [Width-1:0] candidate_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             prime_flag_o
);
  localparam int unsigned ExpW = $clog2(Width + 1);

  typedef enum logic [3:0] {
    StIdle, StTrial, StTrialWait, StSetup, StWit, StWitWait, StPowMul, StPowMulWait,
    StPowSq, StPowSqWait, StCheck, StSqr, StSqrWait, StDone
  } state_e;

  state_e state_q;
  logic [Width-1:0] n_q, d_q, e_q, x_q, acc_q;
  logic [ExpW-1:0] s_q, k_q;
  logic [4:0] sp_q;
  logic [2:0] wi_q;
  logic flag_q, ovalid_q;

  logic rem_start, rem_done, mul_start, mul_done;
  logic [Width-1:0] rem_a, rem_b, rem_r, mul_x, mul_y, mul_p, nm1;

  assign nm1 = n_q - 1'b1;

  mrpt_remainder #(.Width(Width)) u_rem (
    .clk_i, .rst_ni, .start_i(rem_start), .a_i(rem_a), .b_i(rem_b),
    .done_o(rem_done), .r_o(rem_r)
  );
  mrpt_mulmod #(.Width(Width)) u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .x_i(mul_x), .y_i(mul_y), .m_i(n_q),
    .done_o(mul_done), .p_o(mul_p)
  );

  always_comb begin
    rem_start = (state_q == StTrial) || (state_q == StWit);
    rem_a = (state_q == StTrial) ? n_q : Width'(witness(wi_q));
    rem_b = (state_q == StTrial) ? Width'(small_prime(sp_q)) : n_q;
    mul_start = (state_q == StPowMul) || (state_q == StPowSq) || (state_q == StSqr);
    mul_x = (state_q == StPowMul) ? acc_q : x_q;
    mul_y = x_q;
  end

  assign in_ready_o = (state_q == StIdle) && !ovalid_q;
  assign out_valid_o = ovalid_q;
  assign prime_flag_o = flag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; ovalid_q <= 1'b0; flag_q <= 1'b0;
      sp_q <= '0; wi_q <= '0; s_q <= '0; k_q <= '0;
    end else begin
      if (ovalid_q && out_ready_i) ovalid_q <= 1'b0;
      case (state_q)
        StIdle: if (in_valid_i && in_ready_o) begin
          n_q <= candidate_i; sp_q <= '0;
          if (candidate_i < Width'(2)) begin
            flag_q <= 1'b0; state_q <= StDone;
          end else state_q <= StTrial;
        end
        StTrial: state_q <= StTrialWait;
        StTrialWait: if (rem_done) begin
          if (n_q == Width'(small_prime(sp_q))) begin
            flag_q <= 1'b1; state_q <= StDone;
          end else if (rem_r == '0) begin
            flag_q <= 1'b0; state_q <= StDone;
          end else if (sp_q == 5'(SmallCount - 1)) begin
            if (n_q < SmallLimitSq) begin
              flag_q <= 1'b1; state_q <= StDone;
            end else begin
              d_q <= nm1 >> 1; s_q <= ExpW'(1); state_q <= StSetup;
            end
          end else begin
            sp_q <= sp_q + 1'b1; state_q <= StTrial;
          end
        end
        // Strip one factor of two per cycle from n-1.
        StSetup: if (d_q[0]) begin
          wi_q <= '0; state_q <= StWit;
        end else begin
          d_q <= d_q >> 1; s_q <= s_q + 1'b1;
        end
        StWit: state_q <= StWitWait;
        StWitWait: if (rem_done) begin
          if (rem_r == '0) begin
            if (wi_q == 3'(WitCount - 1)) begin
              flag_q <= 1'b1; state_q <= StDone;
            end else begin
              wi_q <= wi_q + 1'b1; state_q <= StWit;
            end
          end else begin
            x_q <= rem_r; e_q <= d_q; acc_q <= Width'(1);
            state_q <= d_q[0] ? StPowMul : StPowSq;
          end
        end
        StPowMul: state_q <= StPowMulWait;
        StPowMulWait: if (mul_done) begin
          acc_q <= mul_p; state_q <= StPowSq;
        end
        StPowSq: state_q <= StPowSqWait;
        StPowSqWait: if (mul_done) begin
          e_q <= e_q >> 1;
          if ((e_q >> 1) == '0) begin
            x_q <= acc_q; k_q <= ExpW'(1); state_q <= StCheck;
          end else begin
            x_q <= mul_p; state_q <= e_q[1] ? StPowMul : StPowSq;
          end
        end
        StCheck: begin
          if (x_q == Width'(1) || x_q == nm1) begin
            if (wi_q == 3'(WitCount - 1)) begin
              flag_q <= 1'b1; state_q <= StDone;
            end else begin
              wi_q <= wi_q + 1'b1; state_q <= StWit;
            end
          end else if (k_q >= s_q) begin
            flag_q <= 1'b0; state_q <= StDone;
          end else state_q <= StSqr;
        end
        StSqr: state_q <= StSqrWait;
        StSqrWait: if (mul_done) begin
          k_q <= k_q + 1'b1;
          if (mul_p == nm1) begin
            x_q <= mul_p;
            if (wi_q == 3'(WitCount - 1)) begin
              flag_q <= 1'b1; state_q <= StDone;
            end else begin
              wi_q <= wi_q + 1'b1; state_q <= StWit;
            end
          end else if (mul_p == Width'(1)) begin
            // Further squares stay at one and never reach n-1, so the witness holds.
            flag_q <= 1'b0; state_q <= StDone;
          end else begin
            x_q <= mul_p; state_q <= StCheck;
          end
        end
        StDone: if (!ovalid_q) begin
          ovalid_q <= 1'b1; state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule
